FILE: rtl/whp_pkg.sv
// Shared constants, types and the hash function for the windowed probe hash table.
package whp_pkg;

    // Table geometry. WINDOW_SIZE is a power of two of at least two and divides
    // CAPACITY. The table is split into WINDOW_SIZE banks by the low slot bits,
    // so one window touches every bank exactly once.
    localparam int CAPACITY     = 1024;
    localparam int WINDOW_SIZE  = 8;
    localparam int NUM_BANKS    = WINDOW_SIZE;
    localparam int ROWS         = CAPACITY / NUM_BANKS;
    localparam int SLOT_BITS    = $clog2(CAPACITY);
    localparam int BANK_BITS    = $clog2(NUM_BANKS);
    localparam int ROW_BITS     = $clog2(ROWS);

    // Item field widths
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 11;
    localparam int STATUS_W = 3;

    // Hash constants
    localparam logic [63:0] HASH_SEED = 64'hedef335f00e170b3;
    localparam logic [63:0] HASH_MULT = 64'd2685821657736338717;
    localparam int          SHIFT_A   = 12;
    localparam int          SHIFT_B   = 25;
    localparam int          SHIFT_C   = 27;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_MISS = 3'd1,
        ST_DUP  = 3'd2,
        ST_FULL = 3'd3,
        ST_ZERO = 3'd4
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                load;       // item accepted this cycle
        logic                clear;      // clearing pass writes a row of valid marks
        logic [ROW_BITS-1:0] clear_row;
        logic                check;      // bank read data is present, take the decision
        logic                commit;     // write the table, load the result register
    } whp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic zero_key;   // key on the input is zero
        logic out_free;   // result register can take a new item this cycle
    } whp_stat_t;

    // Start slot of the probe window. Only the low slot bits of the product are
    // needed, and those depend only on the low slot bits of both factors.
    function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [KEY_W-1:0] k_in);
        logic [KEY_W-1:0]       k;
        logic [2*SLOT_BITS-1:0] prod;
        k = k_in ^ HASH_SEED;
        k = k ^ (k >> SHIFT_A);
        k = k ^ (k << SHIFT_B);
        k = k ^ (k >> SHIFT_C);
        prod = k[SLOT_BITS-1:0] * HASH_MULT[SLOT_BITS-1:0];
        return prod[SLOT_BITS-1:0];
    endfunction

endpackage

FILE: rtl/windowed_probe_hash_table.sv
// Top level of the windowed probe hash table: controller plus datapath.
//
// Key/value table of 1024 buckets, split into 8 banks by the low slot bits so
// that all 8 buckets of the probe window are read together, one from each bank.
// After reset the block runs a clearing pass over the 128 rows of valid marks
// and holds req_stall high until it is done. Each item then goes from accept
// to result load through accept and hash, bank read, window match, and table
// write and result load; an item with a zero key skips the bank read and the
// window match. The sequencer takes one item at a time. The result sits in an
// output register, so the next item is taken while a result waits; a result
// still waiting when the following item reaches its final step holds that item
// there. status: 0 found or inserted, 1 not found, 2 key already present
// (value_out gives the stored value), 3 window full, 4 zero key.
module windowed_probe_hash_table
    import whp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                op,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  value_out,
    output logic [COUNT_W-1:0]  entry_count
);

    whp_cmd_t  cmd;
    whp_stat_t stat;

    // Sequencer
    whp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table and result path
    whp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

endmodule

FILE: rtl/whp_bank.sv
// One bank of the table: valid mark, key and value memories with registered reads.
module whp_bank
    import whp_pkg::*;
(
    input  logic                clk,
    input  logic [ROW_BITS-1:0] rd_row,
    output logic                rd_flag,
    output logic [KEY_W-1:0]    rd_key,
    output logic [VALUE_W-1:0]  rd_value,
    input  logic                wr_en,
    input  logic [ROW_BITS-1:0] wr_row,
    input  logic                wr_flag,
    input  logic                wr_kv,
    input  logic [KEY_W-1:0]    wr_key,
    input  logic [VALUE_W-1:0]  wr_value
);

    logic               flag_mem  [ROWS];
    logic [KEY_W-1:0]   key_mem   [ROWS];
    logic [VALUE_W-1:0] value_mem [ROWS];

    // Write port: valid mark always, key and value only on insert
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_row] <= wr_flag;
            if (wr_kv)
            begin
                key_mem[wr_row]   <= wr_key;
                value_mem[wr_row] <= wr_value;
            end
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        rd_flag  <= flag_mem[rd_row];
        rd_key   <= key_mem[rd_row];
        rd_value <= value_mem[rd_row];
    end

endmodule

FILE: rtl/whp_dp.sv
// Datapath: hash, banked table, window match and priority pick, count and result register.
module whp_dp
    import whp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  whp_cmd_t            cmd,
    output whp_stat_t           stat,
    input  logic                op,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  value_out,
    output logic [COUNT_W-1:0]  entry_count
);

    // Item registers
    logic                 op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [SLOT_BITS-1:0] base_reg;

    // Decision registers
    status_t              dec_status_reg;
    logic [VALUE_W-1:0]   dec_value_reg;
    logic                 dec_insert_reg;
    logic [BANK_BITS-1:0] ins_bank_reg;
    logic [ROW_BITS-1:0]  ins_row_reg;

    // Count and result registers
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 rsp_valid_reg;
    status_t              out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    // Bank read data
    logic [NUM_BANKS-1:0] rd_flag;
    logic [KEY_W-1:0]     rd_key   [NUM_BANKS];
    logic [VALUE_W-1:0]   rd_value [NUM_BANKS];
    logic [NUM_BANKS-1:0] bank_hit;

    // Window decision
    logic [2*NUM_BANKS-1:0] hit_dbl;
    logic [2*NUM_BANKS-1:0] empty_dbl;
    logic [NUM_BANKS-1:0]   ord_hit;
    logic [NUM_BANKS-1:0]   ord_empty;
    logic                   found;
    logic                   sel_hit;
    logic [BANK_BITS-1:0]   sel_idx;
    logic [BANK_BITS-1:0]   sel_bank;
    logic [SLOT_BITS-1:0]   sel_slot;
    status_t                chk_status;
    logic [VALUE_W-1:0]     chk_value;
    logic                   chk_insert;

    // Status to the controller
    assign stat.zero_key = (key == '0);
    assign stat.out_free = !rsp_valid_reg || !rsp_stall;

    // Banks: each reads the row its window slot falls in
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [BANK_BITS-1:0] pidx;
        logic [SLOT_BITS-1:0] slot;
        logic                 wr_en;
        logic [ROW_BITS-1:0]  wr_row;

        assign pidx   = BANK_BITS'(b) - base_reg[BANK_BITS-1:0];
        assign slot   = base_reg + SLOT_BITS'(pidx);
        assign wr_en  = cmd.clear || (cmd.commit && dec_insert_reg &&
                                      (ins_bank_reg == BANK_BITS'(b)));
        assign wr_row = cmd.clear ? cmd.clear_row : ins_row_reg;

        whp_bank u_bank (
            .clk      (clk),
            .rd_row   (slot[SLOT_BITS-1:BANK_BITS]),
            .rd_flag  (rd_flag[b]),
            .rd_key   (rd_key[b]),
            .rd_value (rd_value[b]),
            .wr_en    (wr_en),
            .wr_row   (wr_row),
            .wr_flag  (!cmd.clear),
            .wr_kv    (!cmd.clear),
            .wr_key   (key_reg),
            .wr_value (value_reg)
        );

        assign bank_hit[b] = rd_flag[b] && (rd_key[b] == key_reg);
    end

    // Put the banks into probe order, then pick the first usable bucket
    assign hit_dbl   = {bank_hit, bank_hit} >> base_reg[BANK_BITS-1:0];
    assign empty_dbl = {~rd_flag, ~rd_flag} >> base_reg[BANK_BITS-1:0];
    assign ord_hit   = hit_dbl[NUM_BANKS-1:0];
    assign ord_empty = empty_dbl[NUM_BANKS-1:0];

    always_comb
    begin
        found   = 1'b0;
        sel_hit = 1'b0;
        sel_idx = '0;
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            if (!found && (ord_hit[i] || (op_reg == OP_PUT && ord_empty[i])))
            begin
                found   = 1'b1;
                sel_hit = ord_hit[i];
                sel_idx = BANK_BITS'(i);
            end
        end
    end

    assign sel_bank = base_reg[BANK_BITS-1:0] + sel_idx;
    assign sel_slot = base_reg + SLOT_BITS'(sel_idx);

    // Outcome of the window
    always_comb
    begin
        chk_value  = '0;
        chk_insert = 1'b0;
        if (found && sel_hit)
        begin
            chk_status = (op_reg == OP_PUT) ? ST_DUP : ST_OK;
            chk_value  = rd_value[sel_bank];
        end
        else if (found)
        begin
            chk_status = ST_OK;
            chk_insert = 1'b1;
        end
        else
        begin
            chk_status = (op_reg == OP_PUT) ? ST_FULL : ST_MISS;
        end
    end

    // Item and decision registers; a zero key keeps the load-time decision
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= op;
            key_reg        <= key;
            value_reg      <= value;
            base_reg       <= hash_slot(key);
            dec_status_reg <= ST_ZERO;
            dec_value_reg  <= '0;
            dec_insert_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            dec_status_reg <= chk_status;
            dec_value_reg  <= chk_value;
            dec_insert_reg <= chk_insert;
            ins_bank_reg   <= sel_bank;
            ins_row_reg    <= sel_slot[SLOT_BITS-1:BANK_BITS];
        end
    end

    // Entry count after this item
    assign count_next = count_reg + COUNT_W'(dec_insert_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= dec_status_reg;
            out_value_reg  <= dec_value_reg;
            out_count_reg  <= count_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = out_status_reg;
    assign value_out   = out_value_reg;
    assign entry_count = out_count_reg;

endmodule

FILE: rtl/whp_ctrl.sv
// Controller: clearing pass after reset and the per-item sequence.
module whp_ctrl
    import whp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  whp_stat_t stat,
    output whp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_CHECK  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [ROW_BITS-1:0] clear_row_reg;
    logic [ROW_BITS-1:0] clear_row_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        clear_row_next = clear_row_reg;
        cmd            = '0;
        cmd.clear_row  = clear_row_reg;
        req_stall      = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear      = 1'b1;
                clear_row_next = clear_row_reg + 1'b1;
                if (clear_row_reg == ROW_BITS'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.zero_key ? S_FINISH : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_row_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_row_reg <= clear_row_next;
        end
    end

endmodule
